// ----- design/vac_pkg.sv -----
// Package for the alphabet Vigenere cipher block: sizes, command and
// register codes, and the key selection type shared by the modules.
// No dependencies.
package vac_pkg;

  localparam int ALPHABET_MAX = 256;
  localparam int KEY_MAX      = 64;
  localparam int CHAR_W       = 8;
  localparam int CHAR_NUM     = 256;
  localparam int SLOT_W       = 8;
  localparam int SIZE_W       = 9;
  localparam int KLEN_W       = 7;
  localparam int KCNT_W       = 9;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int ALPHA_AW     = $clog2(ALPHABET_MAX);
  localparam int KEY_AW       = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(26);
  localparam logic [KLEN_W-1:0] KLEN_RESET   = KLEN_W'(1);

  typedef enum logic [1:0] {
    CMD_ALPHA = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_MSG   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHABET_SIZE = 2'd0,
    REG_KEY_LENGTH    = 2'd1,
    REG_DECRYPT       = 2'd2,
    REG_AUTOKEY       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_AW-1:0] pos;
    logic              use_hist;
  } key_sel_t;

endpackage

// ----- design/vigenere_alphabet_cipher.sv -----
// Top level of the Vigenere cipher over a loadable alphabet.
// Depends on vac_pkg, vac_ram and vac_keyseq.

// The block takes one beat per clock cycle on the input stream when it is
// ready. A load beat (write alphabet entry or write key symbol) is written
// into the tables in the cycle it is accepted and gives no result; a message
// beat travels a five-stage pipeline (key store read, reverse-map lookup of
// message and key character, membership check, modular add or subtract with
// the final alphabet read, output register) and its result beat is offered
// from the output register. Back-pressure moves stage by stage, so empty
// stages are filled while a result waits. A load beat waits while a message
// sits in the first three stages, since those still read the tables; a
// stalled result can hold that message there. In decrypt autokey mode a
// message whose key is plaintext still being deciphered waits until that
// plaintext has been written, which only occurs with key lengths below
// five. Configuration writes are taken on any cycle the block is idle.
// Character membership is held in 256 valid flip-flops cleared by reset,
// so there is no clearing pass.
module vigenere_alphabet_cipher import vac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [7:0] slot, [15:8] char_value
  input  logic [2:0]           in_tuser,   // [1:0] command, [2] message_start
  // Result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_char
  output logic [0:0]           out_tuser,  // [0] not_in_alphabet
  // Configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [SIZE_W-1:0] alphabet_size_r;
  logic [KLEN_W-1:0] key_length_r;
  logic              decrypt_r;
  logic              autokey_r;
  logic [SIZE_W-1:0] size_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alphabet_size_r <= SIZE_RESET;
      key_length_r    <= KLEN_RESET;
      decrypt_r       <= 1'b0;
      autokey_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHABET_SIZE: alphabet_size_r <= cfg_wdata[SIZE_W-1:0];
        REG_KEY_LENGTH:    key_length_r    <= cfg_wdata[KLEN_W-1:0];
        REG_DECRYPT:       decrypt_r       <= cfg_wdata[0];
        REG_AUTOKEY:       autokey_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sizes beyond the table act as the full table.
  assign size_eff = (alphabet_size_r > SIZE_W'(ALPHABET_MAX)) ? SIZE_W'(ALPHABET_MAX)
                                                             : alphabet_size_r;

  // Input beat fields.
  logic [1:0]        in_cmd;
  logic              in_start;
  logic [SLOT_W-1:0] in_slot;
  logic [CHAR_W-1:0] in_char;

  assign in_cmd   = in_tuser[1:0];
  assign in_start = in_tuser[2];
  assign in_slot  = in_tdata[7:0];
  assign in_char  = in_tdata[15:8];

  // Pipeline stage registers.
  logic                s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic [CHAR_W-1:0]   s1_char_r, s2_char_r, s3_char_r, s4_char_r;
  logic [KEY_AW-1:0]   s1_pos_r, s2_pos_r, s3_pos_r, s4_pos_r;
  logic                s1_hist_r;
  logic [CHAR_W-1:0]   s2_key_char_r, s3_key_char_r;
  logic                s2_mvalid_r, s2_kvalid_r;
  logic [ALPHA_AW-1:0] s3_mi_r, s3_ki_r;
  logic                s3_pre_ok_r;
  logic                s4_ok_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_flag_r;

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic en_out, en4, en3, en2, en1;

  assign en_out = !out_valid_r || out_tready;
  assign en4    = !s4_valid_r || en_out;
  assign en3    = !s3_valid_r || en4;
  assign en2    = !s2_valid_r || en3;
  assign en1    = !s1_valid_r || en2;

  // Key position sequencing.
  key_sel_t key_sel;
  logic     accept, msg_acc;

  vac_keyseq u_keyseq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (msg_acc),
    .restart    (in_start),
    .key_length (key_length_r),
    .autokey    (autokey_r),
    .sel        (key_sel)
  );

  // Loads must not overtake messages that still read the tables. When
  // deciphering with autokey, the history entry for this key slot may still
  // be on its way down the pipeline.
  logic is_load, load_block, hist_block;

  assign is_load    = (in_cmd == CMD_ALPHA) || (in_cmd == CMD_KEY);
  assign load_block = is_load && (s1_valid_r || s2_valid_r || s3_valid_r);
  assign hist_block = (in_cmd == CMD_MSG) && decrypt_r && key_sel.use_hist &&
                      ((s1_valid_r && (s1_pos_r == key_sel.pos)) ||
                       (s2_valid_r && (s2_pos_r == key_sel.pos)) ||
                       (s3_valid_r && (s3_pos_r == key_sel.pos)) ||
                       (s4_valid_r && (s4_pos_r == key_sel.pos)));

  assign in_tready = en1 && !load_block && !hist_block;
  assign accept    = in_tvalid && in_tready;
  assign msg_acc   = accept && (in_cmd == CMD_MSG);

  // Table writes from load beats.
  logic alpha_we, key_we;

  assign alpha_we = accept && (in_cmd == CMD_ALPHA) &&
                    ((SLOT_W + 1)'(in_slot) < (SLOT_W + 1)'(ALPHABET_MAX));
  assign key_we   = accept && (in_cmd == CMD_KEY) &&
                    ((SLOT_W + 1)'(in_slot) < (SLOT_W + 1)'(KEY_MAX));

  // Character membership valid bits; an entry not yet loaded is not a member.
  logic char_valid_r [CHAR_NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAR_NUM; i++) begin
        char_valid_r[i] <= 1'b0;
      end
    end else if (alpha_we) begin
      char_valid_r[in_char] <= 1'b1;
    end
  end

  // Plaintext history write: at acceptance when enciphering (the plaintext
  // is the message character), at the last stage when deciphering.
  logic              hist_we;
  logic [KEY_AW-1:0] hist_waddr;
  logic [CHAR_W-1:0] hist_wdata;
  logic [CHAR_W-1:0] s4_out_char;
  logic [CHAR_W-1:0] s4_plain;

  always_comb begin
    if (decrypt_r) begin
      hist_we    = s4_valid_r && en_out;
      hist_waddr = s4_pos_r;
      hist_wdata = s4_plain;
    end else begin
      hist_we    = msg_acc;
      hist_waddr = key_sel.pos;
      hist_wdata = in_char;
    end
  end

  // Stage 0 reads: key store and plaintext history at the key position.
  logic [CHAR_W-1:0] key_rdata, hist_rdata;

  vac_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_slot[KEY_AW-1:0]),
    .wdata (in_char),
    .re    (en1),
    .raddr (key_sel.pos),
    .rdata (key_rdata)
  );

  vac_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (en1),
    .raddr (key_sel.pos),
    .rdata (hist_rdata)
  );

  // Stage 1: reverse-map lookups of message and key characters.
  logic [CHAR_W-1:0]   s1_key_char;
  logic [ALPHA_AW-1:0] mi_rdata, ki_rdata;

  assign s1_key_char = s1_hist_r ? hist_rdata : key_rdata;

  vac_ram #(.WIDTH(ALPHA_AW), .DEPTH(CHAR_NUM)) u_c2i_msg_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (in_char),
    .wdata (in_slot[ALPHA_AW-1:0]),
    .re    (en2),
    .raddr (s1_char_r),
    .rdata (mi_rdata)
  );

  vac_ram #(.WIDTH(ALPHA_AW), .DEPTH(CHAR_NUM)) u_c2i_key_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (in_char),
    .wdata (in_slot[ALPHA_AW-1:0]),
    .re    (en2),
    .raddr (s1_key_char),
    .rdata (ki_rdata)
  );

  // Stage 2: forward reads at both indexes to confirm the entries still
  // hold these characters, and range checks against the alphabet size.
  logic [CHAR_W-1:0] mchk_rdata, kchk_rdata;
  logic              s2_pre_ok;

  assign s2_pre_ok = s2_mvalid_r && s2_kvalid_r &&
                     (SIZE_W'(mi_rdata) < size_eff) && (SIZE_W'(ki_rdata) < size_eff);

  vac_ram #(.WIDTH(CHAR_W), .DEPTH(ALPHABET_MAX)) u_i2c_msg_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (in_slot[ALPHA_AW-1:0]),
    .wdata (in_char),
    .re    (en3),
    .raddr (mi_rdata),
    .rdata (mchk_rdata)
  );

  vac_ram #(.WIDTH(CHAR_W), .DEPTH(ALPHABET_MAX)) u_i2c_key_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (in_slot[ALPHA_AW-1:0]),
    .wdata (in_char),
    .re    (en3),
    .raddr (ki_rdata),
    .rdata (kchk_rdata)
  );

  // Stage 3: membership result and the modular sum. Both indexes are below
  // the size when the beat is valid, so one conditional subtract suffices.
  logic                s3_ok;
  logic [SIZE_W:0]     sum;
  logic [SIZE_W:0]     sum_mod;
  logic [ALPHA_AW-1:0] res_idx;
  logic [CHAR_W-1:0]   res_rdata;

  assign s3_ok = s3_pre_ok_r && (mchk_rdata == s3_char_r) && (kchk_rdata == s3_key_char_r);

  always_comb begin
    if (decrypt_r) begin
      sum = (SIZE_W + 1)'(s3_mi_r) + (SIZE_W + 1)'(size_eff) - (SIZE_W + 1)'(s3_ki_r);
    end else begin
      sum = (SIZE_W + 1)'(s3_mi_r) + (SIZE_W + 1)'(s3_ki_r);
    end
    sum_mod = (sum >= (SIZE_W + 1)'(size_eff)) ? sum - (SIZE_W + 1)'(size_eff) : sum;
    res_idx = sum_mod[ALPHA_AW-1:0];
  end

  vac_ram #(.WIDTH(CHAR_W), .DEPTH(ALPHABET_MAX)) u_i2c_res_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (in_slot[ALPHA_AW-1:0]),
    .wdata (in_char),
    .re    (en4),
    .raddr (res_idx),
    .rdata (res_rdata)
  );

  // Stage 4: result character and the plaintext kept for autokey.
  assign s4_out_char = s4_ok_r ? res_rdata : '0;
  assign s4_plain    = (decrypt_r && s4_ok_r) ? res_rdata : s4_char_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= msg_acc;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (en4) begin
        s4_valid_r <= s3_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_char_r <= in_char;
      s1_pos_r  <= key_sel.pos;
      s1_hist_r <= key_sel.use_hist;
    end
    if (en2) begin
      s2_char_r     <= s1_char_r;
      s2_key_char_r <= s1_key_char;
      s2_pos_r      <= s1_pos_r;
      s2_mvalid_r   <= char_valid_r[s1_char_r];
      s2_kvalid_r   <= char_valid_r[s1_key_char];
    end
    if (en3) begin
      s3_char_r     <= s2_char_r;
      s3_key_char_r <= s2_key_char_r;
      s3_pos_r      <= s2_pos_r;
      s3_mi_r       <= mi_rdata;
      s3_ki_r       <= ki_rdata;
      s3_pre_ok_r   <= s2_pre_ok;
    end
    if (en4) begin
      s4_char_r <= s3_char_r;
      s4_pos_r  <= s3_pos_r;
      s4_ok_r   <= s3_ok;
    end
    if (en_out) begin
      out_char_r <= s4_out_char;
      out_flag_r <= !s4_ok_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_char_r;
  assign out_tuser[0] = out_flag_r;

endmodule

// ----- design/vac_ram.sv -----
// Generic single-write, single-read RAM with a registered, enabled read.
// A read of the address being written returns the old contents.
// No dependencies.
module vac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/vac_keyseq.sv -----
// Key position sequencer: picks the key slot for each message beat and
// whether the key comes from the key store or the plaintext history.
// Depends on vac_pkg.
module vac_keyseq import vac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              restart,
  input  logic [KLEN_W-1:0] key_length,
  input  logic              autokey,
  output key_sel_t          sel
);

  logic [KEY_AW-1:0] key_position_r, key_position_nxt;
  logic              key_exhausted_r, key_exhausted_nxt;
  logic [KCNT_W-1:0] klen;
  logic [KCNT_W-1:0] pos_start;
  logic [KCNT_W-1:0] pos_inc;
  logic [KEY_AW-1:0] pos_cur;
  logic              exh_start;

  always_comb begin
    if (key_length == '0) begin
      klen = KCNT_W'(1);
    end else if (KCNT_W'(key_length) > KCNT_W'(KEY_MAX)) begin
      klen = KCNT_W'(KEY_MAX);
    end else begin
      klen = KCNT_W'(key_length);
    end
    pos_start = restart ? '0 : KCNT_W'(key_position_r);
    exh_start = restart ? 1'b0 : key_exhausted_r;
    // A key length lowered mid-message sends the position back to the start.
    pos_cur   = (pos_start >= klen) ? '0 : pos_start[KEY_AW-1:0];
    pos_inc   = KCNT_W'(pos_cur) + KCNT_W'(1);
    if (pos_inc >= klen) begin
      key_position_nxt  = '0;
      key_exhausted_nxt = 1'b1;
    end else begin
      key_position_nxt  = pos_inc[KEY_AW-1:0];
      key_exhausted_nxt = exh_start;
    end
  end

  assign sel.pos      = pos_cur;
  assign sel.use_hist = autokey & exh_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_position_r  <= '0;
      key_exhausted_r <= 1'b0;
    end else if (step) begin
      key_position_r  <= key_position_nxt;
      key_exhausted_r <= key_exhausted_nxt;
    end
  end

endmodule

// ----- design/vac_checker.sv -----
// Port-level checker for the alphabet Vigenere cipher block, bound to the
// top level. Depends on vigenere_alphabet_cipher's port list.
module vac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser
);

  // A result beat held back keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A flagged result carries a zero character.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
    else $error("flagged result with non-zero character");

  // Reset empties the pipeline: no result and room for a new beat.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind vigenere_alphabet_cipher vac_checker u_vac_checker (.*);

// ----- verif/vac_cipher_sb_pkg.sv -----
// Scoreboard for the alphabet Vigenere cipher testbench. It predicts each result
// beat from the accepted input beats and checks the result beats in order.
// Depends on vac_pkg for sizes, command codes and register codes.
package vac_cipher_sb_pkg;
  import vac_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              flag;
  } cipher_out_t;

  class cipher_scoreboard;
    bit [CHAR_W-1:0] pos_char   [ALPHABET_MAX];
    bit [SLOT_W-1:0] char_pos   [CHAR_NUM];
    bit              char_known [CHAR_NUM];
    bit [CHAR_W-1:0] key_sym    [KEY_MAX];
    bit [CHAR_W-1:0] plain_hist [KEY_MAX];
    bit              hist_seen  [KEY_MAX];
    int unsigned     key_pos;
    bit              key_done;
    bit [SIZE_W-1:0] alpha_size;
    bit [KLEN_W-1:0] key_len;
    bit              decrypt;
    bit              autokey;
    cipher_out_t     expected_chars[$];
    int unsigned     failures;

    function new();
      key_pos    = 0;
      key_done   = 1'b0;
      alpha_size = SIZE_RESET;
      key_len    = KLEN_RESET;
      decrypt    = 1'b0;
      autokey    = 1'b0;
      failures   = 0;
    endfunction

    function void set_reg(cfg_reg_t r, bit [CFG_W-1:0] v);
      case (r)
        REG_ALPHABET_SIZE: alpha_size = v[SIZE_W-1:0];
        REG_KEY_LENGTH:    key_len    = v[KLEN_W-1:0];
        REG_DECRYPT:       decrypt    = v[0];
        REG_AUTOKEY:       autokey    = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned active_size();
      return (alpha_size > ALPHABET_MAX) ? ALPHABET_MAX : alpha_size;
    endfunction

    function int unsigned active_keylen();
      if (key_len == 0) return 1;
      return (key_len > KEY_MAX) ? KEY_MAX : key_len;
    endfunction

    // A character counts only if its reverse entry is live, inside the active
    // size, and the forward table still holds it at that position.
    function bit find_char(bit [CHAR_W-1:0] c, output int unsigned idx);
      idx = 0;
      if (!char_known[c]) return 1'b0;
      if (char_pos[c] >= active_size()) return 1'b0;
      if (pos_char[char_pos[c]] != c) return 1'b0;
      idx = char_pos[c];
      return 1'b1;
    endfunction

    // True when the next message would take its key from a history entry
    // that no message has written yet.
    function bit history_missing();
      int unsigned p;
      p = (key_pos >= active_keylen()) ? 0 : key_pos;
      return autokey && key_done && !hist_seen[p];
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void note_beat(bit [1:0] cmd, bit [SLOT_W-1:0] slot, bit [CHAR_W-1:0] ch,
                            bit start);
      int unsigned     klen, p, mi, ki, sz, r;
      bit [CHAR_W-1:0] keych, outc;
      bit              ok_m, ok_k, ok;
      cipher_out_t     res;
      if (cmd == CMD_ALPHA) begin
        pos_char[slot] = ch;
        char_pos[ch]   = slot;
        char_known[ch] = 1'b1;
        return;
      end
      if (cmd == CMD_KEY) begin
        if (slot < KEY_MAX) key_sym[slot] = ch;
        return;
      end
      if (cmd != CMD_MSG) return;

      if (start) begin
        key_pos  = 0;
        key_done = 1'b0;
      end
      klen = active_keylen();
      if (key_pos >= klen) key_pos = 0;
      p     = key_pos;
      keych = (autokey && key_done) ? plain_hist[p] : key_sym[p];
      ok_m  = find_char(ch, mi);
      ok_k  = find_char(keych, ki);
      ok    = ok_m && ok_k;
      sz    = active_size();
      outc  = '0;
      if (ok) begin
        r = decrypt ? mi + sz - ki : mi + ki;
        if (r >= sz) r -= sz;
        outc = pos_char[r];
      end
      plain_hist[p] = (decrypt && ok) ? outc : ch;
      hist_seen[p]  = 1'b1;
      p++;
      if (p >= klen) begin
        p        = 0;
        key_done = 1'b1;
      end
      key_pos  = p;
      res.ch   = outc;
      res.flag = !ok;
      expected_chars.push_back(res);
    endfunction

    function void check_beat(logic [CHAR_W-1:0] ch, logic flag);
      cipher_out_t e;
      if (expected_chars.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: char %02h flag %b", ch, flag);
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== ch || e.flag !== flag) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: expected char %02h flag %b, got char %02h flag %b",
                   e.ch, e.flag, ch, flag);
      end
    endfunction
  endclass

endpackage

// ----- verif/tb_vigenere_alphabet_cipher.sv -----
// Top-level testbench for vigenere_alphabet_cipher: drives load, message and
// configuration traffic with random idling and checks every result beat.
// Depends on vac_pkg and vac_cipher_sb_pkg.
module tb_vigenere_alphabet_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import vac_pkg::*;
  import vac_cipher_sb_pkg::*;

  // The command encoding that the block must ignore.
  localparam bit [1:0] CMD_NONE = 2'd3;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 8;
  // The long receiver hold-off happens once, early in this phase, which runs
  // at full rate and carries extra beats so that the sender keeps offering.
  localparam int PRESS_PHASE     = 2;
  localparam int PRESS_EXTRA     = 12;
  localparam int HOLD_CYCLES     = 80;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // [7:0] slot, [15:8] char_value
  logic [2:0]           in_tuser   = '0;   // [1:0] command, [2] message_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [7:0] out_char
  logic [0:0]           out_tuser;         // [0] not_in_alphabet
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  cipher_scoreboard board;
  // When set, neither side idles; it is switched per phase so that some
  // stretches run at full rate.
  bit               quiet        = 1'b0;
  // Set by the sender when the pressure phase begins.
  bit               hold_armed   = 1'b0;

  // Settings for each phase: alphabet size, key length, decrypt, autokey.
  // Zero and out-of-range values of size and length are among them on purpose.
  bit [SIZE_W-1:0] phase_size [NUM_PHASES] =
    '{26, 26, 256, 256, 1, 0, 511, 100, 37, 200, 26, 256};
  bit [KLEN_W-1:0] phase_klen [NUM_PHASES] =
    '{5, 5, 64, 64, 1, 3, 2, 0, 127, 3, 4, 7};
  bit              phase_dec  [NUM_PHASES] = '{0, 1, 0, 1, 0, 0, 1, 0, 1, 1, 0, 1};
  bit              phase_auto [NUM_PHASES] = '{0, 0, 1, 1, 0, 0, 1, 1, 0, 1, 1, 1};

  vigenere_alphabet_cipher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one beat after a random gap and returns at the edge where it was
  // taken. Handshake signals are sampled straight after the rising edge, so
  // they still hold the values that the block saw at that edge. The valid is
  // only lowered when a gap follows, so it never gets two assignments in one
  // step.
  task automatic send_beat(input bit [1:0] cmd, input bit [7:0] slot,
                           input bit [7:0] ch, input bit start);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ch, slot};
    in_tuser  <= {start, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_beat(cmd, slot, ch, start);
  endtask

  // Registers only change while the block is idle: every expected result
  // has been seen, and then a pause longer than the pipeline lets any load or
  // ignored beat still in flight drain out.
  task automatic write_settings(input bit [SIZE_W-1:0] size, input bit [KLEN_W-1:0] klen,
                                input bit dec, input bit ak);
    cfg_reg_t       regs [4];
    bit [CFG_W-1:0] vals [4];
    regs = '{REG_ALPHABET_SIZE, REG_KEY_LENGTH, REG_DECRYPT, REG_AUTOKEY};
    vals = '{CFG_W'(size), CFG_W'(klen), CFG_W'(dec), CFG_W'(ak)};
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    foreach (regs[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly message characters drawn from the active alphabet, so that most
  // results are real cipher output; the rest are table rewrites (which leave
  // stale reverse entries behind), key rewrites, some in the ignored slot
  // range, and ignored commands. A message restarts the key whenever autokey
  // would otherwise read plaintext history that was never written.
  task automatic send_random_beat();
    int unsigned pick, sz, kl;
    bit [1:0]    cmd;
    bit [7:0]    slot, ch;
    bit          start;
    pick  = $urandom_range(0, 99);
    sz    = board.active_size();
    kl    = board.active_keylen();
    slot  = 8'($urandom);
    ch    = 8'($urandom);
    start = 1'($urandom);
    if (pick < 72) begin
      cmd = CMD_MSG;
      if (sz > 0 && $urandom_range(0, 4) != 0) ch = board.pos_char[$urandom_range(0, sz - 1)];
      start = ($urandom_range(0, 11) == 0) || board.history_missing();
    end else if (pick < 82) begin
      cmd = CMD_ALPHA;
    end else if (pick < 95) begin
      cmd = CMD_KEY;
      if ($urandom_range(0, 3) != 0) slot = 8'($urandom_range(0, kl - 1));
      if (sz > 0 && $urandom_range(0, 3) != 0) ch = board.pos_char[$urandom_range(0, sz - 1)];
    end else begin
      cmd = CMD_NONE;
    end
    send_beat(cmd, slot, ch, start);
  endtask

  initial begin : stimulus
    bit [7:0]    perm [256];
    bit [7:0]    t;
    int unsigned j;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With nothing loaded into the alphabet every message is flagged. Only key
    // slot 0 is read at the reset key length, so it is written first.
    send_beat(CMD_KEY, 8'h00, 8'h41, 1'b0);
    send_beat(CMD_MSG, 8'h00, 8'h41, 1'b1);
    send_beat(CMD_NONE, 8'hFF, 8'hFF, 1'b1);

    // Fill every table position with a shuffled byte, and every key slot with
    // a character from the reset-size alphabet, so that no later read meets an
    // entry that was never written.
    foreach (perm[i]) perm[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < ALPHABET_MAX; i++) send_beat(CMD_ALPHA, i[7:0], perm[i], 1'($urandom));
    for (int i = 0; i < KEY_MAX; i++) send_beat(CMD_KEY, i[7:0], perm[$urandom_range(0, 25)], 1'b0);

    // Directed cases at the reset settings: lowest and highest index, a
    // character present in the table but beyond the active size, key loads to
    // slots outside the key store, a character written at two positions, a
    // key character outside the alphabet and ignored commands.
    send_beat(CMD_MSG, 8'h00, perm[0], 1'b1);
    send_beat(CMD_MSG, 8'hFF, perm[25], 1'b0);
    send_beat(CMD_MSG, 8'h00, perm[200], 1'b0);
    send_beat(CMD_KEY, 8'd64, perm[200], 1'b0);
    send_beat(CMD_KEY, 8'hFF, 8'h00, 1'b1);
    send_beat(CMD_MSG, 8'h00, perm[1], 1'b0);
    send_beat(CMD_ALPHA, 8'd3, perm[5], 1'b0);
    send_beat(CMD_MSG, 8'h00, perm[3], 1'b0);
    send_beat(CMD_MSG, 8'h00, perm[5], 1'b0);
    send_beat(CMD_ALPHA, 8'd3, perm[3], 1'b0);
    send_beat(CMD_ALPHA, 8'd5, perm[5], 1'b0);
    send_beat(CMD_KEY, 8'd0, perm[100], 1'b0);
    send_beat(CMD_MSG, 8'h00, perm[2], 1'b0);
    send_beat(CMD_KEY, 8'd0, perm[7], 1'b0);
    send_beat(CMD_MSG, 8'hAA, perm[9], 1'b1);
    send_beat(CMD_NONE, 8'h00, 8'h00, 1'b0);
    send_beat(CMD_NONE, 8'h55, 8'hAA, 1'b1);

    // Random phases, each under its own settings. A phase that shortens the
    // key without a message restart makes the key position fall out of range.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_settings(phase_size[ph], phase_klen[ph], phase_dec[ph], phase_auto[ph]);
      quiet = (ph % 3 == 2);
      if (ph == PRESS_PHASE) hold_armed = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE + ((ph == PRESS_PHASE) ? PRESS_EXTRA : 0); n++)
        send_random_beat();
    end

    in_tvalid <= 1'b0;
    for (int n = 0; n < 5000 && board.pending() > 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each beat, except in quiet phases.
  // Once in the run it holds off long enough for the pipeline to fill and
  // push back on the input while the sender keeps offering beats.
  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (hold_armed && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_beat(out_tdata, out_tuser[0]);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
